// ===== rtl/sv39_page_table_mapper_unit_defines.svh =====
// Assertion macros shared by the Sv39 page-table mapper RTL.
`ifndef SV39_PAGE_TABLE_MAPPER_UNIT_DEFINES_SVH
`define SV39_PAGE_TABLE_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sptm_pkg.sv =====
// Shared types and constants of the Sv39 page-table mapper.
`timescale 1ns / 1ps
`default_nettype none
package sptm_pkg;

  localparam int unsigned POOL_PAGES_DEF = 64;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned PPN_W = 44;
  localparam int unsigned VPN_W = 27;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned PERM_W = 10;
  localparam int unsigned RPAGE_W = 6;
  // Wide enough for a free-page index up to the largest pool.
  localparam int unsigned NFP_W = 11;
  localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524288;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OUT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LVL_ROOT = 2'd0,
    LVL_MID  = 2'd1,
    LVL_LEAF = 2'd2,
    LVL_WORD = 2'd3
  } level_t;

  typedef struct packed {
    logic   clear;
    logic   load;
    logic   rd;
    level_t lvl;
    logic   eval;
    logic   wr_leaf;
    logic   get_word;
  } cmd_t;

  typedef struct packed {
    logic    clear_last;
    logic    is_read;
    logic    read_out;
    logic    count_zero;
    logic    last;
    status_t rc;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/sptm_ctrl.sv =====
// Controller state machine of the Sv39 page-table mapper.
`timescale 1ns / 1ps
`default_nettype none
module sptm_ctrl
  import sptm_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  output logic  busy,
  output logic  out_valid,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RD_ROOT, S_EV_ROOT, S_RD_MID, S_EV_MID,
    S_RD_LEAF, S_WR_LEAF, S_RD_WORD, S_GET_WORD, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (stat.clear_last) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.read_out) state_nxt = S_DONE;
        else if (stat.is_read) state_nxt = S_RD_WORD;
        else if (stat.count_zero) state_nxt = S_DONE;
        else state_nxt = S_RD_ROOT;
      end
      S_RD_ROOT:  state_nxt = S_EV_ROOT;
      S_EV_ROOT:  state_nxt = (stat.rc != ST_OK) ? S_DONE : S_RD_MID;
      S_RD_MID:   state_nxt = S_EV_MID;
      S_EV_MID:   state_nxt = (stat.rc != ST_OK) ? S_DONE : S_RD_LEAF;
      S_RD_LEAF:  state_nxt = S_WR_LEAF;
      S_WR_LEAF:  state_nxt = stat.last ? S_DONE : S_RD_ROOT;
      S_RD_WORD:  state_nxt = S_GET_WORD;
      S_GET_WORD: state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == S_DONE);
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.lvl      = LVL_ROOT;
    cmd.clear    = (state_r == S_CLEAR);
    cmd.load     = (state_r == S_IDLE) && start;
    cmd.eval     = (state_r == S_EV_ROOT) || (state_r == S_EV_MID);
    cmd.wr_leaf  = (state_r == S_WR_LEAF);
    cmd.get_word = (state_r == S_GET_WORD);
    case (state_r)
      S_RD_ROOT: begin
        cmd.rd  = 1'b1;
        cmd.lvl = LVL_ROOT;
      end
      S_RD_MID: begin
        cmd.rd  = 1'b1;
        cmd.lvl = LVL_MID;
      end
      S_RD_LEAF: begin
        cmd.rd  = 1'b1;
        cmd.lvl = LVL_LEAF;
      end
      S_RD_WORD: begin
        cmd.rd  = 1'b1;
        cmd.lvl = LVL_WORD;
      end
      default: cmd.rd = 1'b0;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/sptm_datapath.sv =====
// Datapath of the Sv39 page-table mapper: table pool, walk registers and results.
`timescale 1ns / 1ps
`default_nettype none
module sptm_datapath
  import sptm_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  wire                cfg_wr,
  input  wire  [PPN_W-1:0]   cfg_data,
  input  wire                in_operation,
  input  wire  [VPN_W-1:0]   in_virt_page,
  input  wire  [PPN_W-1:0]   in_phys_page,
  input  wire  [CNT_W-1:0]   in_page_count,
  input  wire  [PERM_W-1:0]  in_perm_bits,
  input  wire  [RPAGE_W-1:0] in_read_page,
  input  wire  [IDX_W-1:0]   in_read_entry,
  output logic [1:0]         out_status,
  output logic [6:0]         out_pages_used,
  output logic [63:0]        out_read_word
);

  localparam int unsigned PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned AW    = PW + IDX_W;
  localparam int unsigned DEPTH = POOL_PAGES * ENTRIES_PER_PAGE;

  logic [63:0]        mem [DEPTH];
  logic [63:0]        rdata_r;
  logic [AW-1:0]      addr_r, raddr, waddr;
  logic [AW-1:0]      clr_r;
  logic               we;
  logic [63:0]        wdata;

  logic [PPN_W-1:0]   base_r;
  logic [NFP_W-1:0]   nfp_r;
  logic [PW-1:0]      page_r;
  logic [VPN_W-1:0]   vpn_r;
  logic [PPN_W-1:0]   ppn_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PERM_W-1:0]  perm_r;
  logic               op_r;
  logic [NFP_W-1:0]   rpage_r;
  logic [IDX_W-1:0]   rentry_r;
  status_t            status_r;
  logic [63:0]        word_r;

  logic [PPN_W-1:0]   rel;
  logic [PPN_W-1:0]   new_ppn;
  logic               ent_valid;
  logic               pool_full;
  status_t            rc;
  logic [IDX_W-1:0]   idx;
  logic [PW-1:0]      pg;

  assign ent_valid = rdata_r[0];
  assign rel       = rdata_r[PPN_W+9:10] - base_r;
  assign new_ppn   = base_r + PPN_W'(nfp_r);
  assign pool_full = (nfp_r >= NFP_W'(POOL_PAGES));

  always_comb begin
    if (ent_valid) rc = (rel >= PPN_W'(POOL_PAGES)) ? ST_OUT : ST_OK;
    else rc = pool_full ? ST_FULL : ST_OK;
  end

  always_comb begin
    pg = page_r;
    case (cmd.lvl)
      LVL_ROOT: idx = vpn_r[26:18];
      LVL_MID:  idx = vpn_r[17:9];
      LVL_LEAF: idx = vpn_r[8:0];
      LVL_WORD: begin
        idx = rentry_r;
        pg  = rpage_r[PW-1:0];
      end
      default:  idx = vpn_r[8:0];
    endcase
    raddr = {pg, idx};
  end

  // The pool is swept to zero after reset; afterwards writes come from the walk.
  always_comb begin
    waddr = addr_r;
    wdata = {rdata_r[63:54], ppn_r, perm_r};
    we    = 1'b0;
    if (cmd.clear) begin
      waddr = clr_r;
      wdata = '0;
      we    = 1'b1;
    end else if (cmd.eval) begin
      wdata = {rdata_r[63:54], new_ppn, 10'd1};
      we    = !ent_valid && (rc == ST_OK);
    end else if (cmd.wr_leaf) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      nfp_r  <= NFP_W'(1);
      base_r <= POOL_BASE_RESET;
    end else begin
      if (cmd.clear) clr_r <= clr_r + AW'(1);
      if (cfg_wr) base_r <= cfg_data;
      if (cmd.eval && !ent_valid && (rc == ST_OK)) nfp_r <= nfp_r + NFP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      vpn_r    <= in_virt_page;
      ppn_r    <= in_phys_page;
      cnt_r    <= in_page_count;
      perm_r   <= in_perm_bits;
      rpage_r  <= NFP_W'(in_read_page);
      rentry_r <= in_read_entry;
      page_r   <= '0;
      word_r   <= '0;
      status_r <= (in_operation && (NFP_W'(in_read_page) >= NFP_W'(POOL_PAGES)))
                  ? ST_OUT : ST_OK;
    end
    if (cmd.rd) addr_r <= raddr;
    if (cmd.eval) begin
      if (rc != ST_OK) status_r <= rc;
      else page_r <= ent_valid ? rel[PW-1:0] : nfp_r[PW-1:0];
    end
    if (cmd.wr_leaf) begin
      page_r <= '0;
      vpn_r  <= vpn_r + VPN_W'(1);
      ppn_r  <= ppn_r + PPN_W'(1);
      cnt_r  <= cnt_r - CNT_W'(1);
    end
    if (cmd.get_word) word_r <= rdata_r;
  end

  assign stat.clear_last = (clr_r == AW'(DEPTH - 1));
  assign stat.is_read    = op_r;
  assign stat.read_out   = op_r && (status_r == ST_OUT);
  assign stat.count_zero = (cnt_r == '0);
  assign stat.last       = (cnt_r == CNT_W'(1));
  assign stat.rc         = rc;

  assign out_status     = status_r;
  assign out_pages_used = nfp_r[6:0];
  assign out_read_word  = word_r;

endmodule
`default_nettype wire

// ===== rtl/sv39_page_table_mapper_unit.sv =====
// Top level of the Sv39 page-table mapper: controller, datapath and checks.
//
//  Channel  Handshake              Payload
//  in_      start / busy           operation, virt_page, phys_page, page_count,
//                                  perm_bits, read_page, read_entry
//  out_     out_valid (one cycle)  status, pages_used, read_word
//  cfg_     cfg_valid / cfg_ready  pool_base_page
//
// A map transfer does one read and one evaluate or write per table level on the
// single-port pool memory. A read outside the pool skips the memory read, and a
// map that stops on a status ends early. After reset the pool memory is cleared
// one word per cycle, all POOL_PAGES * 512 words, with busy high; configuration
// writes are taken throughout.
// Each result is shown for one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
`include "sv39_page_table_mapper_unit_defines.svh"
module sv39_page_table_mapper_unit
  import sptm_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire                in_operation,
  input  wire  [VPN_W-1:0]   in_virt_page,
  input  wire  [PPN_W-1:0]   in_phys_page,
  input  wire  [CNT_W-1:0]   in_page_count,
  input  wire  [PERM_W-1:0]  in_perm_bits,
  input  wire  [RPAGE_W-1:0] in_read_page,
  input  wire  [IDX_W-1:0]   in_read_entry,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_pages_used,
  output logic [63:0]        out_read_word,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [PPN_W-1:0]   cfg_pool_base_page
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sptm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  sptm_datapath #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_pool_base_page),
    .in_operation   (in_operation),
    .in_virt_page   (in_virt_page),
    .in_phys_page   (in_phys_page),
    .in_page_count  (in_page_count),
    .in_perm_bits   (in_perm_bits),
    .in_read_page   (in_read_page),
    .in_read_entry  (in_read_entry),
    .out_status     (out_status),
    .out_pages_used (out_pages_used),
    .out_read_word  (out_read_word)
  );

  `SPTM_ASSERT_NOW(a_strobe_busy, out_valid, busy, "result strobe while idle")
  `SPTM_ASSERT_NEXT(a_strobe_ends, out_valid, !busy && !out_valid, "result not followed by idle")
  `SPTM_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `SPTM_ASSERT_NOW(a_status_code, out_valid, out_status != 2'd3, "undefined status code")

endmodule
`default_nettype wire
